// File: design/atfrcd_pkg.sv
`timescale 1ns / 1ps

package atfrcd_pkg;

  // widths of the item fields
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned COUNT_W = 10;

  // window of recent bytes plus the new byte covers the longest string
  localparam int unsigned WIN_DEPTH = 17;
  localparam int unsigned SPAN      = WIN_DEPTH + 1;

  // request kinds
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  // final result codes
  typedef enum logic [CODE_W-1:0] {
    RC_PENDING = 3'd0,
    RC_OK      = 3'd1,
    RC_ERROR   = 3'd2,
    RC_READY   = 3'd3,
    RC_HWFAIL  = 3'd4,
    RC_SBDRING = 3'd5
  } result_code_t;

  // final result strings, last character in the low byte
  localparam int unsigned LEN_OK      = 4;
  localparam int unsigned LEN_ERROR   = 7;
  localparam int unsigned LEN_READY   = 7;
  localparam int unsigned LEN_HWFAIL  = 18;
  localparam int unsigned LEN_SBDRING = 9;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;

  localparam logic [8*LEN_OK-1:0]      PAT_OK      = {"OK", CHAR_CR, CHAR_LF};
  localparam logic [8*LEN_ERROR-1:0]   PAT_ERROR   = {"ERROR", CHAR_CR, CHAR_LF};
  localparam logic [8*LEN_READY-1:0]   PAT_READY   = {"READY", CHAR_CR, CHAR_LF};
  localparam logic [8*LEN_HWFAIL-1:0]  PAT_HWFAIL  = {"HARDWARE FAILURE", CHAR_CR, CHAR_LF};
  localparam logic [8*LEN_SBDRING-1:0] PAT_SBDRING = {"SBDRING", CHAR_CR, CHAR_LF};

endpackage

// File: design/atfrcd_req_if.sv
`timescale 1ns / 1ps

interface atfrcd_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic [atfrcd_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

// File: design/atfrcd_res_if.sv
`timescale 1ns / 1ps

interface atfrcd_res_if;
  logic                            valid;
  logic                            ready;
  logic [atfrcd_pkg::CODE_W-1:0]   result_code;
  logic                            done_res;
  logic [atfrcd_pkg::COUNT_W-1:0]  byte_count;

  modport source (output valid, output result_code, output done_res, output byte_count,
                  input ready);
  modport sink   (input valid, input result_code, input done_res, input byte_count,
                  output ready);
endinterface

// File: design/at_final_result_code_detector.sv
`timescale 1ns / 1ps
// the result item is registered and offered in the cycle after its item is accepted
// throughput: one item per cycle while rsp takes results; the state registers double
//   as output; a new item is taken in the same cycle as the pending result is taken
// reset (rst, synchronous): window, latched code and byte count clear, no result pending
module at_final_result_code_detector #(
  parameter int unsigned MAX_LEN = 512
) (
  input  logic                clk,
  input  logic                rst,
  atfrcd_req_if.sink          req,
  atfrcd_res_if.source        rsp
);

  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic [8*atfrcd_pkg::WIN_DEPTH-1:0] window;
  logic [8*atfrcd_pkg::WIN_DEPTH-1:0] window_next;
  atfrcd_pkg::result_code_t           code;
  atfrcd_pkg::result_code_t           code_next;
  atfrcd_pkg::result_code_t           match_code;
  logic [CNT_W-1:0]                   count;
  logic [CNT_W-1:0]                   count_next;
  logic                               rsp_valid;
  logic [8*atfrcd_pkg::SPAN-1:0]      span;
  logic                               accept;

  // a slot is free when no result waits or the waiting one leaves now
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // newest byte sits in the low byte of the span
  assign span = {window, req.rx_byte};

  // compare the tail of the span with each string, first in list wins
  always_comb begin
    priority if (span[8*atfrcd_pkg::LEN_OK-1:0] == atfrcd_pkg::PAT_OK) begin
      match_code = atfrcd_pkg::RC_OK;
    end else if (span[8*atfrcd_pkg::LEN_ERROR-1:0] == atfrcd_pkg::PAT_ERROR) begin
      match_code = atfrcd_pkg::RC_ERROR;
    end else if (span[8*atfrcd_pkg::LEN_READY-1:0] == atfrcd_pkg::PAT_READY) begin
      match_code = atfrcd_pkg::RC_READY;
    end else if (span[8*atfrcd_pkg::LEN_HWFAIL-1:0] == atfrcd_pkg::PAT_HWFAIL) begin
      match_code = atfrcd_pkg::RC_HWFAIL;
    end else if (span[8*atfrcd_pkg::LEN_SBDRING-1:0] == atfrcd_pkg::PAT_SBDRING) begin
      match_code = atfrcd_pkg::RC_SBDRING;
    end else begin
      match_code = atfrcd_pkg::RC_PENDING;
    end
  end

  // next detector state for the item on the input
  always_comb begin
    window_next = window;
    code_next   = code;
    count_next  = count;
    if (req.req_type == atfrcd_pkg::REQ_RESTART) begin
      window_next = '0;
      code_next   = atfrcd_pkg::RC_PENDING;
      count_next  = '0;
    end else if (code == atfrcd_pkg::RC_PENDING) begin
      window_next = span[8*atfrcd_pkg::WIN_DEPTH-1:0];
      code_next   = match_code;
      if (count < CNT_W'(MAX_LEN)) begin
        count_next = count + CNT_W'(1);
      end
    end
  end

  // state registers, which also hold the result on offer
  always_ff @(posedge clk) begin
    if (rst) begin
      window    <= '0;
      code      <= atfrcd_pkg::RC_PENDING;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        window <= window_next;
        code   <= code_next;
        count  <= count_next;
      end
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result item
  assign rsp.valid       = rsp_valid;
  assign rsp.result_code = code;
  assign rsp.done_res    = (code != atfrcd_pkg::RC_PENDING);
  assign rsp.byte_count  = atfrcd_pkg::COUNT_W'(count);

endmodule

// File: bench/at_final_result_code_detector_tb.sv
`timescale 1ns / 1ps

module at_final_result_code_detector_tb;

  localparam int unsigned DET_MAX_LEN = 512;
  localparam int unsigned TOTAL_ITEMS = 400;

  // one reply item as the block should present it
  typedef struct packed {
    atfrcd_pkg::result_code_t           code;
    logic                               done;
    logic [atfrcd_pkg::COUNT_W-1:0]     count;
  } reply_t;

  // tracks the detector state and the replies still owed by the block
  class reply_tracker;
    logic [8*atfrcd_pkg::WIN_DEPTH-1:0] window;
    atfrcd_pkg::result_code_t           latched;
    int unsigned                        taken;
    reply_t                             expected_replies[$];
    int unsigned                        failures;
    int unsigned                        checked;
    int unsigned                        code_hits[6];
    bit                                 saturated;

    function new();
      window    = '0;
      latched   = atfrcd_pkg::RC_PENDING;
      taken     = 0;
      failures  = 0;
      checked   = 0;
      saturated = 1'b0;
      foreach (code_hits[i]) code_hits[i] = 0;
    endfunction

    // work out the reply to one accepted request; returns 1 if the byte is dropped
    function bit take_request(logic kind, logic [atfrcd_pkg::BYTE_W-1:0] data);
      logic [8*atfrcd_pkg::SPAN-1:0] span;
      reply_t                        want;
      bit                            dropped;
      dropped = 1'b0;
      if (kind == atfrcd_pkg::REQ_RESTART) begin
        window  = '0;
        latched = atfrcd_pkg::RC_PENDING;
        taken   = 0;
      end else if (latched == atfrcd_pkg::RC_PENDING) begin
        span   = {window, data};
        window = span[8*atfrcd_pkg::WIN_DEPTH-1:0];
        if (taken < DET_MAX_LEN) taken++;
        if (taken == DET_MAX_LEN) saturated = 1'b1;
        // earliest string in the priority order wins
        if (span[8*atfrcd_pkg::LEN_OK-1:0] == atfrcd_pkg::PAT_OK)
          latched = atfrcd_pkg::RC_OK;
        else if (span[8*atfrcd_pkg::LEN_ERROR-1:0] == atfrcd_pkg::PAT_ERROR)
          latched = atfrcd_pkg::RC_ERROR;
        else if (span[8*atfrcd_pkg::LEN_READY-1:0] == atfrcd_pkg::PAT_READY)
          latched = atfrcd_pkg::RC_READY;
        else if (span[8*atfrcd_pkg::LEN_HWFAIL-1:0] == atfrcd_pkg::PAT_HWFAIL)
          latched = atfrcd_pkg::RC_HWFAIL;
        else if (span[8*atfrcd_pkg::LEN_SBDRING-1:0] == atfrcd_pkg::PAT_SBDRING)
          latched = atfrcd_pkg::RC_SBDRING;
        if (latched != atfrcd_pkg::RC_PENDING) code_hits[latched]++;
      end else begin
        dropped = 1'b1;
      end
      want.code  = latched;
      want.done  = (latched != atfrcd_pkg::RC_PENDING);
      want.count = atfrcd_pkg::COUNT_W'(taken);
      expected_replies.push_back(want);
      return dropped;
    endfunction

    // compare one accepted reply with the oldest one owed
    function void check_reply(logic [atfrcd_pkg::CODE_W-1:0] code, logic done,
                              logic [atfrcd_pkg::COUNT_W-1:0] count);
      reply_t want;
      reply_t got;
      got.code  = atfrcd_pkg::result_code_t'(code);
      got.done  = done;
      got.count = count;
      if (expected_replies.size() == 0) begin
        failures++;
        $display("%0t: reply with none owed, code %0d done %0b count %0d",
                 $time, code, done, count);
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (want !== got) begin
        failures++;
        $display("%0t: reply mismatch, expected code %0d done %0b count %0d",
                 $time, want.code, want.done, want.count);
        $display("%0t:   got code %0d done %0b count %0d", $time, code, done, count);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst;
  int           idle_pct = 33;
  int unsigned  sent_items;
  int unsigned  dropped_items;
  int unsigned  responses;
  reply_tracker tracker = new();

  string final_words[5] = '{"OK", "ERROR", "READY", "HARDWARE FAILURE", "SBDRING"};
  string filler_chars   = "OKERADYHWFILUSBNG +:,0123456789";

  atfrcd_req_if req_ch ();
  atfrcd_res_if rsp_ch ();

  at_final_result_code_detector #(
    .MAX_LEN(DET_MAX_LEN)
  ) uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  // reply side stalls at random
  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
  end

  // check every reply item taken
  always @(posedge clk) begin
    if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      tracker.check_reply(rsp_ch.result_code, rsp_ch.done_res, rsp_ch.byte_count);
  end

  // offer one item, with random gaps before it; entered and left at a falling edge
  task automatic send_item(input logic kind, input logic [atfrcd_pkg::BYTE_W-1:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= data;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    sent_items++;
    if (tracker.take_request(kind, data)) dropped_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(atfrcd_pkg::REQ_BYTE, s[i]);
  endtask

  // final result string, optionally with one bit flipped or the line feed left off
  task automatic send_final(input int unsigned idx, input bit flip, input bit with_lf);
    string                         body;
    int unsigned                   spot;
    logic [atfrcd_pkg::BYTE_W-1:0] c;
    body = final_words[idx];
    spot = $urandom_range(0, body.len() - 1);
    for (int i = 0; i < body.len(); i++) begin
      c = body[i];
      if (flip && i == spot) c ^= atfrcd_pkg::BYTE_W'(1 << $urandom_range(0, 7));
      send_item(atfrcd_pkg::REQ_BYTE, c);
    end
    send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_CR);
    if (with_lf) send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_LF);
  endtask

  // echo text, intermediate lines and line noise
  task automatic send_filler();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3)
      send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::BYTE_W'($urandom_range(0, 255)));
    else if (roll == 3) send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_CR);
    else if (roll == 4) send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_LF);
    else send_item(atfrcd_pkg::REQ_BYTE,
                   filler_chars[$urandom_range(0, filler_chars.len() - 1)]);
  endtask

  // one modem response: mostly a restart, noise, maybe a partial string, mostly a final string, noise
  task automatic send_response();
    int unsigned pick;
    if ($urandom_range(0, 7) != 0)
      send_item(atfrcd_pkg::REQ_RESTART, atfrcd_pkg::BYTE_W'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 10)) send_filler();
    pick = $urandom_range(0, 4);
    if ($urandom_range(0, 4) == 0)
      send_text(final_words[pick].substr(0, $urandom_range(0, final_words[pick].len() - 1)));
    case ($urandom_range(0, 9))
      7: send_final(pick, 1'b1, 1'b1);
      8: send_final(pick, 1'b0, 1'b0);
      9: send_filler();
      default: send_final(pick, 1'b0, 1'b1);
    endcase
    repeat ($urandom_range(0, 4)) send_filler();
  endtask

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.req_type = atfrcd_pkg::REQ_BYTE;
    req_ch.rx_byte  = '0;
    rst             = 1'b1;
    sent_items      = 0;
    dropped_items   = 0;
    responses       = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: restart with all ones, byte extremes, OK, byte after latch
    send_item(atfrcd_pkg::REQ_RESTART, 8'hff);
    send_item(atfrcd_pkg::REQ_BYTE, 8'h00);
    send_item(atfrcd_pkg::REQ_BYTE, 8'hff);
    send_final(int'(atfrcd_pkg::RC_OK) - 1, 1'b0, 1'b1);
    send_item(atfrcd_pkg::REQ_BYTE, "X");
    // a string split by a restart must not match
    send_item(atfrcd_pkg::REQ_RESTART, 8'h00);
    send_item(atfrcd_pkg::REQ_BYTE, "O");
    send_item(atfrcd_pkg::REQ_RESTART, 8'ha5);
    send_text("K");
    send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_CR);
    send_item(atfrcd_pkg::REQ_BYTE, atfrcd_pkg::CHAR_LF);
    send_item(atfrcd_pkg::REQ_RESTART, 8'h5a);
    send_final(int'(atfrcd_pkg::RC_SBDRING) - 1, 1'b0, 1'b1);

    // random responses, with a stretch where neither side idles
    while (sent_items < TOTAL_ITEMS) begin
      idle_pct = (responses >= 8 && responses < 18) ? 0 : 33;
      send_response();
      responses++;
    end
    idle_pct = 33;
    req_ch.valid <= 1'b0;

    while (tracker.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    $display("%0d items sent (%0d ignored after a latch), %0d replies checked, %0d responses",
             sent_items, dropped_items, tracker.checked, responses);
    $display("latched OK/ERROR/READY/HW FAILURE/SBDRING: %0d/%0d/%0d/%0d/%0d, count %s",
             tracker.code_hits[atfrcd_pkg::RC_OK], tracker.code_hits[atfrcd_pkg::RC_ERROR],
             tracker.code_hits[atfrcd_pkg::RC_READY], tracker.code_hits[atfrcd_pkg::RC_HWFAIL],
             tracker.code_hits[atfrcd_pkg::RC_SBDRING],
             tracker.saturated ? "saturated" : "below saturation");
    if (tracker.failures == 0) begin
      $display("at_final_result_code_detector_tb: PASS");
    end else begin
      $display("at_final_result_code_detector_tb: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("at_final_result_code_detector_tb: FAIL");
    $finish;
  end

endmodule

// File: at_final_result_code_detector.f
design/atfrcd_pkg.sv
design/atfrcd_req_if.sv
design/atfrcd_res_if.sv
design/at_final_result_code_detector.sv
bench/at_final_result_code_detector_tb.sv
